FILE: hw/rtl/srs_pkg.sv
// Shared types, codes and checksum function for the selective-repeat sender.
// No dependencies; every other file imports this package.
`default_nettype none
package srs_pkg;
	localparam int SEQ_W      = 16;
	localparam int CSUM_W     = 18;
	localparam int WL_W       = 4;
	localparam int QL_W       = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int PAYLOAD_BYTES = 20;

	typedef enum logic [1:0] {
		OP_MSG = 2'd0,
		OP_ACK = 2'd1,
		OP_TMO = 2'd2,
		OP_RSV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_SEND   = 2'd0,
		K_RESEND = 2'd1,
		K_ACK    = 2'd2,
		K_DROP   = 2'd3
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE  = 2'd1;

	typedef struct packed {
		logic [31:0] high;
		logic [63:0] mid;
		logic [63:0] low;
	} payload_t;

	typedef struct packed {
		op_t              op;
		payload_t         pl;
		logic [SEQ_W-1:0] seq;
	} item_t;

	function automatic logic [CSUM_W-1:0] byte_sum(input payload_t p);
		logic [CSUM_W-1:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + CSUM_W'(p.low[8*i +: 8]) + CSUM_W'(p.mid[8*i +: 8]);
		end
		for (int i = 0; i < 4; i++) begin
			s = s + CSUM_W'(p.high[8*i +: 8]);
		end
		return s;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/srs_if.sv
// Channel interfaces: request beats, result beats and configuration writes.
// Depends on srs_pkg for field widths.
`default_nettype none
interface srs_in_if import srs_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [63:0]      payload_low;
	logic [63:0]      payload_mid;
	logic [31:0]      payload_high;
	logic [SEQ_W-1:0] seq_field;
	modport source (output valid, op, payload_low, payload_mid, payload_high, seq_field,
		input ready);
	modport sink (input valid, op, payload_low, payload_mid, payload_high, seq_field,
		output ready);
endinterface

interface srs_out_if import srs_pkg::*;;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [SEQ_W-1:0]  out_seq;
	logic [CSUM_W-1:0] out_checksum;
	logic [63:0]       out_payload_low;
	logic [63:0]       out_payload_mid;
	logic [31:0]       out_payload_high;
	logic              last;
	modport source (output valid, kind, out_seq, out_checksum, out_payload_low,
		out_payload_mid, out_payload_high, last, input ready);
	modport sink (input valid, kind, out_seq, out_checksum, out_payload_low,
		out_payload_mid, out_payload_high, last, output ready);
endinterface

interface srs_cfg_if import srs_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/srs_front.sv
// Front end: accepts request beats, drops unknown ops, holds two items for the engine.
// Depends on srs_pkg and srs_if.
`default_nettype none
module srs_front import srs_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	srs_in_if.sink req,
	output logic  item_valid,
	input  wire   item_ready,
	output item_t item
);
	item_t      buf_q [2];
	logic [1:0] cnt_q;
	logic       push, pop;
	logic       wr_idx;
	item_t      in_item;

	assign req.ready  = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = buf_q[0];
	assign pop        = item_valid && item_ready;
	assign push       = req.valid && req.ready && (op_t'(req.op) != OP_RSV);
	assign wr_idx     = pop ? 1'b0 : cnt_q[0];

	always_comb begin
		in_item.op      = op_t'(req.op);
		in_item.pl.low  = req.payload_low;
		in_item.pl.mid  = req.payload_mid;
		in_item.pl.high = req.payload_high;
		in_item.seq     = req.seq_field;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_idx) begin
			buf_q[0] <= in_item;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
		end
		if (push && wr_idx) begin
			buf_q[1] <= in_item;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/srs_back.sv
// Engine: window slots, message queue memory, slide and drain sequencer, result register.
// Depends on srs_pkg and srs_if.
`default_nettype none
module srs_back import srs_pkg::*; #(
	parameter int WS = 8,
	parameter int FD = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_ready,
	input  item_t      item,
	srs_out_if.source  rsp,
	srs_cfg_if.sink    cfg
);
	localparam int IW  = $clog2(WS + 1);
	localparam int SW  = (WS > 1) ? $clog2(WS) : 1;
	localparam int CW  = $clog2(FD + 1);
	localparam int FAW = (FD > 1) ? $clog2(FD) : 1;

	typedef enum logic [2:0] {S_IDLE, S_SLIDE, S_DRAIN, S_FILL, S_EMIT} state_t;

	state_t            state_q;
	logic [SEQ_W-1:0]  base_q;
	logic [IW-1:0]     inflight_q;
	logic [WS-1:0]     acked_q;
	payload_t          slot_q [WS];
	payload_t          fifo_mem [FD];
	payload_t          rd_q;
	logic [FAW-1:0]    head_q, tail_q;
	logic [CW-1:0]     count_q;
	logic [WL_W-1:0]   wl_q;
	logic [QL_W-1:0]   ql_q;

	kind_t             pk_q;
	logic [SEQ_W-1:0]  ps_q;
	payload_t          pp_q;
	logic              plast_q;

	logic              ov_q;
	kind_t             okind_q;
	logic [SEQ_W-1:0]  oseq_q;
	logic [CSUM_W-1:0] ocsum_q;
	payload_t          opl_q;
	logic              olast_q;

	logic [IW-1:0]     wl;
	logic [CW-1:0]     ql;
	logic [SEQ_W-1:0]  off;
	logic              in_win, can_send, out_free;
	logic              mem_we, mem_re;
	logic              slot_we, slot_shift;
	payload_t          slot_wd;
	logic [CSUM_W-1:0] csum;

	assign wl = (32'(wl_q) > WS) ? IW'(WS) : IW'(wl_q);
	assign ql = (32'(ql_q) > FD) ? CW'(FD) : CW'(ql_q);
	assign off      = item.seq - base_q;
	assign in_win   = (off < SEQ_W'(inflight_q)) && !acked_q[off[SW-1:0]];
	assign can_send = inflight_q < wl;
	assign out_free = !ov_q || rsp.ready;
	assign item_ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign mem_we = (state_q == S_IDLE) && item_valid && (item.op == OP_MSG) && !can_send
		&& (count_q < ql);
	assign mem_re = (state_q == S_DRAIN) && (count_q != '0) && can_send;
	assign slot_we = ((state_q == S_IDLE) && item_valid && (item.op == OP_MSG) && can_send)
		|| (state_q == S_FILL);
	assign slot_wd = (state_q == S_FILL) ? rd_q : item.pl;
	assign slot_shift = (state_q == S_SLIDE) && (inflight_q != '0) && acked_q[0];
	assign csum = ((pk_q == K_SEND) || (pk_q == K_RESEND))
		? byte_sum(pp_q) + {1'b0, ps_q, 1'b0} : '0;

	assign rsp.valid            = ov_q;
	assign rsp.kind             = okind_q;
	assign rsp.out_seq          = oseq_q;
	assign rsp.out_checksum     = ocsum_q;
	assign rsp.out_payload_low  = opl_q.low;
	assign rsp.out_payload_mid  = opl_q.mid;
	assign rsp.out_payload_high = opl_q.high;
	assign rsp.last             = olast_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fifo_mem[tail_q] <= item.pl;
		end
		if (mem_re) begin
			rd_q <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (slot_shift) begin
			for (int i = 0; i + 1 < WS; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end else if (slot_we) begin
			slot_q[inflight_q[SW-1:0]] <= slot_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			base_q     <= SEQ_W'(1);
			inflight_q <= '0;
			acked_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			wl_q       <= WL_W'(8);
			ql_q       <= QL_W'(50);
			ov_q       <= 1'b0;
			pk_q       <= K_SEND;
			ps_q       <= '0;
			pp_q       <= '0;
			plast_q    <= 1'b0;
			okind_q    <= K_SEND;
			oseq_q     <= '0;
			ocsum_q    <= '0;
			opl_q      <= '0;
			olast_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_WINDOW: wl_q <= cfg.data[WL_W-1:0];
					REG_QUEUE:  ql_q <= cfg.data;
					default: ;
				endcase
			end
			if (rsp.ready && (state_q != S_EMIT)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						unique case (item.op)
							OP_MSG: begin
								if (can_send) begin
									acked_q[inflight_q[SW-1:0]] <= 1'b0;
									pk_q       <= K_SEND;
									ps_q       <= base_q + SEQ_W'(inflight_q);
									pp_q       <= item.pl;
									plast_q    <= 1'b1;
									inflight_q <= inflight_q + IW'(1);
									state_q    <= S_EMIT;
								end else if (count_q < ql) begin
									tail_q  <= (tail_q == FAW'(FD - 1)) ? '0 : tail_q + FAW'(1);
									count_q <= count_q + CW'(1);
								end else begin
									pk_q    <= K_DROP;
									ps_q    <= '0;
									pp_q    <= item.pl;
									plast_q <= 1'b1;
									state_q <= S_EMIT;
								end
							end
							OP_ACK: begin
								if (in_win) begin
									acked_q[off[SW-1:0]] <= 1'b1;
									pk_q    <= K_ACK;
									ps_q    <= item.seq;
									pp_q    <= '0;
									state_q <= S_SLIDE;
								end
							end
							OP_TMO: begin
								if (in_win) begin
									pk_q    <= K_RESEND;
									ps_q    <= item.seq;
									pp_q    <= slot_q[off[SW-1:0]];
									plast_q <= 1'b1;
									state_q <= S_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				S_SLIDE: begin
					if (slot_shift) begin
						acked_q    <= acked_q >> 1;
						base_q     <= base_q + SEQ_W'(1);
						inflight_q <= inflight_q - IW'(1);
					end else begin
						plast_q <= !((count_q != '0) && can_send);
						state_q <= S_EMIT;
					end
				end
				S_DRAIN: begin
					if (mem_re) begin
						head_q  <= (head_q == FAW'(FD - 1)) ? '0 : head_q + FAW'(1);
						count_q <= count_q - CW'(1);
						state_q <= S_FILL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FILL: begin
					acked_q[inflight_q[SW-1:0]] <= 1'b0;
					pk_q       <= K_SEND;
					ps_q       <= base_q + SEQ_W'(inflight_q);
					pp_q       <= rd_q;
					plast_q    <= !((count_q != '0) && ((inflight_q + IW'(1)) < wl));
					inflight_q <= inflight_q + IW'(1);
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						okind_q <= pk_q;
						oseq_q  <= ps_q;
						ocsum_q <= csum;
						opl_q   <= pp_q;
						olast_q <= plast_q;
						state_q <= plast_q ? S_IDLE : S_DRAIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/selective_repeat_sender.sv
// Top level of the selective-repeat sender: front end, engine and the channel ports.
// Depends on srs_pkg, srs_if, srs_front and srs_back.
//
// A message or timer expiry with a result goes to emit and waits for the result
// register; a queued message or an ignored item is handled in idle alone. An accepted
// ack goes through slide, which moves the base one window slot per step, then emit;
// each message sent from the queue then passes through drain, fill and emit, as its
// read is registered. The front end holds two items, so requests keep arriving while
// the engine works; the result register frees the engine once a result is loaded.
// After reset the window and queue are empty; configuration writes take effect at once.
`default_nettype none
module selective_repeat_sender import srs_pkg::*; #(
	parameter int WINDOW_SLOTS = 8,
	parameter int FIFO_DEPTH   = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	srs_in_if.sink     req,
	srs_out_if.source  rsp,
	srs_cfg_if.sink    cfg
);
	logic  item_valid;
	logic  item_ready;
	item_t item;

	srs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	srs_back #(
		.WS (WINDOW_SLOTS),
		.FD (FIFO_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rsp        (rsp),
		.cfg        (cfg)
	);
endmodule
`default_nettype wire

FILE: hw/rtl/srs_checker.sv
// Port-level checks on the result channel of the selective-repeat sender.
// Depends on srs_pkg; bound to selective_repeat_sender below.
`default_nettype none
module srs_checker import srs_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                valid,
	input wire                ready,
	input wire [1:0]          kind,
	input wire [SEQ_W-1:0]    out_seq,
	input wire [CSUM_W-1:0]   out_checksum,
	input wire [63:0]         out_payload_low,
	input wire [63:0]         out_payload_mid,
	input wire [31:0]         out_payload_high,
	input wire                last
);
	payload_t pl;
	assign pl = {out_payload_high, out_payload_mid, out_payload_low};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result beat withdrawn before it was taken");

	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == K_ACK) |-> (out_checksum == '0) && (pl == '0))
		else $error("ack result carries checksum or payload");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == K_DROP) |-> (out_seq == '0) && (out_checksum == '0) && last)
		else $error("drop result malformed");

	a_csum: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ((kind == K_SEND) || (kind == K_RESEND))
		|-> out_checksum == byte_sum(pl) + {1'b0, out_seq, 1'b0})
		else $error("packet checksum mismatch");
endmodule

bind selective_repeat_sender srs_checker u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.valid            (rsp.valid),
	.ready            (rsp.ready),
	.kind             (rsp.kind),
	.out_seq          (rsp.out_seq),
	.out_checksum     (rsp.out_checksum),
	.out_payload_low  (rsp.out_payload_low),
	.out_payload_mid  (rsp.out_payload_mid),
	.out_payload_high (rsp.out_payload_high),
	.last             (rsp.last)
);
`default_nettype wire

FILE: test/tb_selective_repeat_sender.sv
// Testbench for selective_repeat_sender: random and directed message, ack and timeout beats.
// Depends on srs_pkg and srs_if; predicts every result beat and compares field by field.
`timescale 1ns / 100ps
module tb_selective_repeat_sender;
	import srs_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [15:0] seq;
		logic [17:0] csum;
		payload_t    pl;
		logic        last;
	} beat_t;

	typedef struct {
		op_t         op;
		payload_t    pl;
		logic [15:0] seq;
	} req_t;

	logic clk = 0;
	logic arst_n = 0;
	always #2 clk = ~clk;

	srs_in_if  req ();
	srs_out_if rsp ();
	srs_cfg_if cfg ();

	selective_repeat_sender uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	// sender-side state mirror
	int unsigned win_lim_r, que_lim_r;
	logic [15:0] base_q, next_q;
	logic        slot_ack [8];
	payload_t    slot_pl [8];
	payload_t    fifo_q [$];

	req_t  pending [$];
	beat_t expected [$];
	int    errors = 0;
	int    quiet = 0;
	bit    busy_req = 0;
	bit    calm = 0;

	function automatic int unsigned flight();
		return 32'(16'(next_q - base_q));
	endfunction

	function automatic logic [17:0] sum_bytes(payload_t p);
		logic [17:0] s;
		s = 0;
		for (int i = 0; i < 20; i++) s += 18'(p[8*i +: 8]);
		return s;
	endfunction

	function automatic beat_t pkt(kind_t k, int unsigned off);
		beat_t b;
		b.kind = k;
		b.seq = 16'(base_q + off);
		b.csum = sum_bytes(slot_pl[off]) + 18'(2 * b.seq);
		b.pl = slot_pl[off];
		b.last = 0;
		return b;
	endfunction

	function automatic beat_t launch(payload_t p);
		int unsigned off;
		off = flight();
		slot_pl[off] = p;
		slot_ack[off] = 0;
		next_q = next_q + 1;
		return pkt(K_SEND, off);
	endfunction

	function automatic void predict_sends(req_t r);
		beat_t out [$];
		beat_t b;
		int unsigned off;
		off = 32'(16'(r.seq - base_q));
		case (r.op)
			OP_MSG: begin
				if (flight() < win_lim_r) out.push_back(launch(r.pl));
				else if (fifo_q.size() < que_lim_r) fifo_q.push_back(r.pl);
				else begin
					b.kind = K_DROP; b.seq = 0; b.csum = 0; b.pl = r.pl; b.last = 0;
					out.push_back(b);
				end
			end
			OP_ACK: if (off < flight() && off < 8 && !slot_ack[off]) begin
				slot_ack[off] = 1;
				b.kind = K_ACK; b.seq = r.seq; b.csum = 0; b.pl = '0; b.last = 0;
				out.push_back(b);
				while (flight() > 0 && slot_ack[0]) begin
					for (int i = 0; i < 7; i++) begin
						slot_ack[i] = slot_ack[i+1];
						slot_pl[i] = slot_pl[i+1];
					end
					slot_ack[7] = 0;
					base_q = base_q + 1;
				end
				while (fifo_q.size() > 0 && flight() < win_lim_r)
					out.push_back(launch(fifo_q.pop_front()));
			end
			OP_TMO: if (off < flight() && off < 8 && !slot_ack[off])
				out.push_back(pkt(K_RESEND, off));
			default: ;
		endcase
		if (out.size() > 0) out[out.size()-1].last = 1;
		foreach (out[i]) expected.push_back(out[i]);
	endfunction

	function automatic payload_t rand_pl();
		payload_t p;
		case ($urandom_range(0, 5))
			0: p = '0;
			1: p = '1;
			default: p = {$urandom, $urandom, $urandom, $urandom, $urandom};
		endcase
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 0;
			busy_req = 0;
		end else begin
			if (req.valid && req.ready) begin
				predict_sends('{op_t'(req.op), {req.payload_high, req.payload_mid,
					req.payload_low}, req.seq_field});
				busy_req = 0;
			end
			if (!busy_req && pending.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
				req_t r;
				r = pending.pop_front();
				req.valid <= 1;
				req.op <= r.op;
				req.payload_low <= r.pl.low;
				req.payload_mid <= r.pl.mid;
				req.payload_high <= r.pl.high;
				req.seq_field <= r.seq;
				busy_req = 1;
			end else if (!busy_req) req.valid <= 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp.ready <= 0;
		else begin
			if (rsp.valid && rsp.ready) begin
				if (expected.size() == 0) begin
					$display("%0t: unexpected beat kind %0d seq %0h", $time, rsp.kind, rsp.out_seq);
					errors++;
				end else begin
					beat_t e;
					e = expected.pop_front();
					if (rsp.kind !== e.kind || rsp.out_seq !== e.seq || rsp.out_checksum !== e.csum
						|| rsp.out_payload_low !== e.pl.low || rsp.out_payload_mid !== e.pl.mid
						|| rsp.out_payload_high !== e.pl.high || rsp.last !== e.last) begin
						$display("%0t: expected k%0d s%h c%h p%h l%b, actual k%0d s%h c%h p%h l%b",
							$time, e.kind, e.seq, e.csum, e.pl, e.last, rsp.kind, rsp.out_seq,
							rsp.out_checksum, {rsp.out_payload_high, rsp.out_payload_mid,
							rsp.out_payload_low}, rsp.last);
						errors++;
					end
				end
			end
			rsp.ready <= calm || $urandom_range(0, 99) >= 34;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)
			|| (!busy_req && expected.size() == 0))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drain();
		while (pending.size() > 0 || busy_req || expected.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		if (idx == REG_WINDOW) win_lim_r = (val[3:0] > 8) ? 8 : val[3:0];
		else if (idx == REG_QUEUE) que_lim_r = (val > 64) ? 64 : val;
	endtask

	function automatic void add(op_t op, payload_t p, logic [15:0] s);
		pending.push_back('{op, p, s});
	endfunction

	// seq near the live window so acks and timeouts mostly land
	function automatic logic [15:0] near_seq();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'(base_q + $urandom_range(0, 9) - 1);
	endfunction

	task automatic random_phase(int n);
		repeat (n) begin
			int r;
			r = $urandom_range(0, 99);
			while (pending.size() > 0 || busy_req) @(posedge clk);
			if (r < 45) add(OP_MSG, rand_pl(), 16'($urandom));
			else if (r < 80) add(OP_ACK, '0, near_seq());
			else if (r < 96) add(OP_TMO, rand_pl(), near_seq());
			else add(OP_RSV, rand_pl(), 16'($urandom));
		end
	endtask

	initial begin
		req.valid = 0; req.op = 0; req.payload_low = 0; req.payload_mid = 0;
		req.payload_high = 0; req.seq_field = 0;
		rsp.ready = 0; cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		win_lim_r = 8; que_lim_r = 50; base_q = 1; next_q = 1;
		foreach (slot_ack[i]) slot_ack[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: window of two, queue of one
		write_reg(REG_WINDOW, 7'd2);
		write_reg(REG_QUEUE, 7'd1);
		add(OP_MSG, '0, 0);
		add(OP_MSG, '1, 0);
		add(OP_MSG, {5{32'hA5C3_0F11}}, 0);
		add(OP_MSG, {5{32'h1234_5678}}, 0);
		add(OP_TMO, '0, 16'd1);
		add(OP_TMO, '0, 16'd3);
		add(OP_ACK, '0, 16'd2);
		add(OP_ACK, '0, 16'd2);
		add(OP_TMO, '0, 16'd2);
		add(OP_ACK, '0, 16'hFFFF);
		add(OP_ACK, '0, 16'd1);
		add(OP_RSV, '1, 16'hFFFF);
		wait_drain();

		write_reg(REG_WINDOW, 7'd0);
		write_reg(REG_QUEUE, 7'd0);
		add(OP_MSG, '1, 16'hFFFF);
		add(OP_ACK, '0, 16'd3);
		wait_drain();
		write_reg(REG_WINDOW, 7'd15);
		write_reg(REG_QUEUE, 7'd127);
		random_phase(60);
		wait_drain();

		// wide window, deep queue, long calm stretch
		calm = 1;
		write_reg(REG_WINDOW, 7'd8);
		write_reg(REG_QUEUE, 7'd64);
		random_phase(50);
		wait_drain();
		calm = 0;

		write_reg(REG_WINDOW, 7'd1);
		write_reg(REG_QUEUE, 7'd3);
		random_phase(50);
		wait_drain();
		write_reg(REG_WINDOW, 7'd5);
		write_reg(REG_QUEUE, 7'd50);
		random_phase(50);
		wait_drain();

		if (errors == 0 && expected.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
